@@ hw/rtl/udwc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, byte-class constants and the code point width table.
package udwc_pkg;

  // UTF-8 byte classes: (byte & MASK) == CODE.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] ASCII_CODE = 8'h00;

  // Expected sequence lengths.
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Columns added by one byte, plus the end-of-range mark.
  typedef struct packed {
    logic [2:0] cols;
    logic       last;
  } udwc_work_t;

  // Terminal column width of one code point: 0, 1 or 2.
  function automatic logic [1:0] cp_columns(input logic [20:0] cp);
    logic zero_w;
    logic wide_w;
    zero_w = (cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
             (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF);
    wide_w = (cp >= 21'h1100 && cp <= 21'h115F) || cp == 21'h2329 || cp == 21'h232A ||
             (cp >= 21'h2E80 && cp <= 21'hA4CF) || (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
             (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'hFE10 && cp <= 21'hFE19) ||
             (cp >= 21'hFE30 && cp <= 21'hFE6F) || (cp >= 21'hFF00 && cp <= 21'hFF60) ||
             (cp >= 21'hFFE0 && cp <= 21'hFFE6) || (cp >= 21'h1F300 && cp <= 21'h1FAFF);
    if (zero_w) begin
      return 2'd0;
    end else if (wide_w) begin
      return 2'd2;
    end
    return 2'd1;
  endfunction

endpackage

@@ hw/rtl/udwc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for text bytes and width results.
interface udwc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface udwc_width_if;
  logic        valid;
  logic        ready;
  logic [15:0] column_width;
  logic        saturated;

  modport source (output valid, output column_width, output saturated, input ready);
  modport sink (input valid, input column_width, input saturated, output ready);
endinterface

@@ hw/rtl/udwc_front.sv @@
`timescale 1ns / 1ps
// Front end: UTF-8 sequence decoder that turns each byte into a column increment.
module udwc_front (
  input  logic                 clk,
  input  logic                 rst,
  udwc_byte_if.sink            text,
  output logic                 work_valid,
  input  logic                 work_ready,
  output udwc_pkg::udwc_work_t work
);

  logic [2:0]  seq_len;
  logic [1:0]  seq_rcv;
  logic [20:0] partial;

  logic [2:0]  seq_len_next;
  logic [1:0]  seq_rcv_next;
  logic [20:0] partial_next;
  logic [2:0]  cols;

  logic [7:0]  b;
  logic        is_cont;
  logic [2:0]  lead_len;
  logic [20:0] lead_cp;
  logic [2:0]  lead_cols;
  logic [20:0] cp_cat;
  logic [2:0]  rcv_inc;
  logic        accept;

  assign b          = text.text_byte;
  assign is_cont    = (b & udwc_pkg::CONT_MASK) == udwc_pkg::CONT_CODE;
  assign cp_cat     = {partial[14:0], b[5:0]};
  assign rcv_inc    = {1'b0, seq_rcv} + 3'd1;
  assign text.ready = work_ready;
  assign work_valid = text.valid;
  assign accept     = text.valid && work_ready;

  // Classify the byte as a fresh lead.
  always_comb begin
    lead_len  = udwc_pkg::SEQ_NONE;
    lead_cp   = '0;
    lead_cols = 3'd0;
    priority if ((b & udwc_pkg::ASCII_MASK) == udwc_pkg::ASCII_CODE) begin
      lead_cols = {1'b0, udwc_pkg::cp_columns({13'd0, b})};
    end else if ((b & udwc_pkg::LEAD2_MASK) == udwc_pkg::LEAD2_CODE) begin
      lead_len = udwc_pkg::SEQ_TWO;
      lead_cp  = {16'd0, b[4:0]};
    end else if ((b & udwc_pkg::LEAD3_MASK) == udwc_pkg::LEAD3_CODE) begin
      lead_len = udwc_pkg::SEQ_THREE;
      lead_cp  = {17'd0, b[3:0]};
    end else if ((b & udwc_pkg::LEAD4_MASK) == udwc_pkg::LEAD4_CODE) begin
      lead_len = udwc_pkg::SEQ_FOUR;
      lead_cp  = {18'd0, b[2:0]};
    end else begin
      lead_cols = 3'd1;
    end
  end

  always_comb begin
    seq_len_next = lead_len;
    seq_rcv_next = (lead_len != udwc_pkg::SEQ_NONE) ? 2'd1 : 2'd0;
    partial_next = lead_cp;
    cols         = lead_cols;
    if (seq_len != udwc_pkg::SEQ_NONE && is_cont) begin
      if (rcv_inc >= seq_len) begin
        cols         = {1'b0, udwc_pkg::cp_columns(cp_cat)};
        seq_len_next = udwc_pkg::SEQ_NONE;
        seq_rcv_next = 2'd0;
        partial_next = '0;
      end else begin
        cols         = 3'd0;
        seq_len_next = seq_len;
        seq_rcv_next = rcv_inc[1:0];
        partial_next = cp_cat;
      end
    end else if (seq_len != udwc_pkg::SEQ_NONE) begin
      // Broken sequence: held bytes count one column each, then re-decode.
      cols = {1'b0, seq_rcv} + lead_cols;
    end
    // Flush a sequence left open at the end of the range.
    if (text.last_byte && seq_len_next != udwc_pkg::SEQ_NONE) begin
      cols         = cols + {1'b0, seq_rcv_next};
      seq_len_next = udwc_pkg::SEQ_NONE;
      seq_rcv_next = 2'd0;
      partial_next = '0;
    end
  end

  assign work.cols = cols;
  assign work.last = text.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len <= udwc_pkg::SEQ_NONE;
      seq_rcv <= 2'd0;
      partial <= '0;
    end else if (accept) begin
      seq_len <= seq_len_next;
      seq_rcv <= seq_rcv_next;
      partial <= partial_next;
    end
  end

endmodule

@@ hw/rtl/udwc_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO between the decoder and the accumulator.
module udwc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  udwc_pkg::udwc_work_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output udwc_pkg::udwc_work_t pop_data
);

  udwc_pkg::udwc_work_t mem [udwc_pkg::QUEUE_DEPTH];

  logic [udwc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [udwc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [udwc_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = count < udwc_pkg::QUEUE_CNT_W'(udwc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == udwc_pkg::QUEUE_PTR_W'(udwc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == udwc_pkg::QUEUE_PTR_W'(udwc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/udwc_back.sv @@
`timescale 1ns / 1ps
// Back end: saturating column accumulator and result register.
module udwc_back #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 work_valid,
  output logic                 work_ready,
  input  udwc_pkg::udwc_work_t work,
  udwc_width_if.source         result
);

  logic [WIDTH_BITS-1:0]  total;
  logic                   ovf;
  logic                   out_valid;
  logic [15:0]            out_width;
  logic                   out_sat;

  logic [WIDTH_BITS:0]    sum;
  logic [WIDTH_BITS-1:0]  total_next;
  logic                   ovf_next;
  logic [WIDTH_BITS+15:0] total_ext;
  logic                   out_free;
  logic                   take;

  assign sum        = {1'b0, total} + (WIDTH_BITS + 1)'(work.cols);
  assign total_next = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
  assign ovf_next   = ovf | sum[WIDTH_BITS];
  assign total_ext  = (WIDTH_BITS + 16)'(total_next);

  assign out_free   = !out_valid || result.ready;
  assign work_ready = !work.last || out_free;
  assign take       = work_valid && work_ready;

  assign result.valid        = out_valid;
  assign result.column_width = out_width;
  assign result.saturated    = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && work.last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (work.last) begin
          total <= '0;
          ovf   <= 1'b0;
        end else begin
          total <= total_next;
          ovf   <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && work.last) begin
      out_width <= total_ext[15:0];
      out_sat   <= ovf_next;
    end
  end

endmodule

@@ hw/rtl/utf8_display_width_counter_top.sv @@
`timescale 1ns / 1ps
// Top level of the UTF-8 display width counter.
//
// Counts the terminal columns of a UTF-8 text range, one byte per clock
// while not stalled. Every byte is a transaction on the text channel; the
// byte flagged with last_byte closes the range and yields one transaction
// on the result channel with the column total (saturating at
// 2^WIDTH_BITS - 1, low 16 bits shown) and a sticky saturated flag, after
// which the count restarts. Combining marks count 0, wide East Asian and
// emoji code points count 2, everything else 1; bytes of a broken or
// truncated sequence count 1 each. The decoder takes one byte per cycle
// while the queue has room, and a two-entry queue separates it from the
// accumulator so that a stalled result only blocks the input once the queue
// fills. The closing byte passes through the queue and the result register;
// a result held by the sink does not stop the next range from being counted.
module utf8_display_width_counter_top #(
  parameter int WIDTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  udwc_byte_if.sink     text,
  udwc_width_if.source  result
);

  // Decoder to queue.
  logic                 front_valid;
  logic                 front_ready;
  udwc_pkg::udwc_work_t front_work;

  // Queue to accumulator.
  logic                 back_valid;
  logic                 back_ready;
  udwc_pkg::udwc_work_t back_work;

  // Decode bytes into per-byte column increments.
  udwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .work_valid (front_valid),
    .work_ready (front_ready),
    .work       (front_work)
  );

  // Buffer increments so either side can stall.
  udwc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_work),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_work)
  );

  // Accumulate, saturate and emit at the end of each range.
  udwc_back #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (back_valid),
    .work_ready (back_ready),
    .work       (back_work),
    .result     (result)
  );

endmodule

@@ hw/rtl/udwc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the width counter, bound to the top level.
module udwc_checker #(
  parameter int WIDTH_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_width,
  input logic        out_sat
);

  localparam logic [15:0] MAX_SHOWN = (WIDTH_BITS >= 16) ? 16'hFFFF :
                                      16'((64'd1 << WIDTH_BITS) - 64'd1);

  // Ranges closed at the input but not yet delivered.
  logic [2:0] open_ranges;
  logic       in_close;
  logic       out_take;

  assign in_close = in_valid && in_ready && in_last;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_ranges <= '0;
    end else begin
      open_ranges <= open_ranges + 3'(in_close) - 3'(out_take);
    end
  end

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> open_ranges != 3'd0)
    else $error("result shown with no closed range outstanding");

  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |-> out_width == MAX_SHOWN)
    else $error("saturated result does not show the maximum count");

  a_close_latency: assert property (@(posedge clk) disable iff (rst)
    (in_close && open_ranges == 3'd0 && !out_valid) |=> ##1 out_valid)
    else $error("result did not appear two cycles after an idle close");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_width) && $stable(out_sat))
    else $error("stalled result changed");

endmodule

bind utf8_display_width_counter_top udwc_checker #(
  .WIDTH_BITS (WIDTH_BITS)
) u_udwc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .in_last   (text.last_byte),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_width (result.column_width),
  .out_sat   (result.saturated)
);

@@ tb/tb_utf8_display_width_counter_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 display width counter top level.
module tb_utf8_display_width_counter_top;

  localparam int          WIDTH_BITS   = 16;
  localparam int unsigned TOTAL_MAX    = (1 << WIDTH_BITS) - 1;
  // Cycles without any transaction on either channel before the run is called hung.
  localparam int          STALL_LIMIT  = 2000;
  // Result count at which the receiver starts its long hold-off.
  localparam int          SQUEEZE_AT   = 20;
  localparam int          SQUEEZE_LEN  = 300;
  localparam int          RANDOM_BYTES = 900;
  // Cycles to watch for stray results once every expected total has arrived.
  localparam int          DRAIN_CYCLES = 16;

  // Range limits of the column width table: each one is probed from both sides.
  localparam logic [27:0][20:0] CP_EDGES = {
    21'h0300, 21'h036F, 21'h1AB0, 21'h1AFF, 21'h1DC0, 21'h1DFF, 21'h20D0,
    21'h20FF, 21'h1100, 21'h115F, 21'h2329, 21'h232A, 21'h2E80, 21'hA4CF,
    21'hAC00, 21'hD7A3, 21'hF900, 21'hFAFF, 21'hFE10, 21'hFE19, 21'hFE30,
    21'hFE6F, 21'hFF00, 21'hFF60, 21'hFFE0, 21'hFFE6, 21'h1F300, 21'h1FAFF
  };

  // One expected range total.
  typedef struct packed {
    logic [15:0] cols;
    logic        sat;
  } range_total_t;

  // One row of the directed script: a byte sent reps times, the last copy
  // carrying the end mark; typed rows carry the expected total written in the row.
  typedef struct packed {
    logic [7:0]  octet;
    logic        last;
    logic [31:0] reps;
    logic        typed;
    logic [15:0] cols;
    logic        sat;
  } script_row_t;

  logic clk;
  logic rst;

  udwc_byte_if  text_ch ();
  udwc_width_if width_ch ();

  utf8_display_width_counter_top #(
    .WIDTH_BITS(WIDTH_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .result(width_ch)
  );

  // Totals still owed by the block, oldest first.
  range_total_t totals_due[$];
  script_row_t  script[$];
  // Bytes of the random range being assembled.
  logic [7:0]   range_bytes[$];
  int unsigned  err_cnt = 0;
  int unsigned  n_results = 0;

  // Decoder state of the column predictor.
  logic [2:0]   seq_want = udwc_pkg::SEQ_NONE;
  logic [2:0]   seq_have = '0;
  logic [20:0]  cp_acc = '0;
  int unsigned  col_sum = 0;
  logic         col_sat = 1'b0;

  // Columns of one decoded code point.
  function automatic logic [1:0] glyph_columns(input logic [20:0] cp);
    if (cp inside {[21'h0300:21'h036F], [21'h1AB0:21'h1AFF], [21'h1DC0:21'h1DFF],
                   [21'h20D0:21'h20FF]}) begin
      return 2'd0;
    end
    if (cp inside {[21'h1100:21'h115F], 21'h2329, 21'h232A, [21'h2E80:21'hA4CF],
                   [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF], [21'hFE10:21'hFE19],
                   [21'hFE30:21'hFE6F], [21'hFF00:21'hFF60], [21'hFFE0:21'hFFE6],
                   [21'h1F300:21'h1FAFF]}) begin
      return 2'd2;
    end
    return 2'd1;
  endfunction

  // Add columns to the running total; clamp at the top and remember it.
  function void bump_columns(input int unsigned n);
    if (col_sum + n > TOTAL_MAX) begin
      col_sum = TOTAL_MAX;
      col_sat = 1'b1;
    end else begin
      col_sum = col_sum + n;
    end
  endfunction

  function void drop_pending();
    seq_want = udwc_pkg::SEQ_NONE;
    seq_have = '0;
    cp_acc   = '0;
  endfunction

  // Decode a byte that arrives with no sequence open.
  function void take_lead_octet(input logic [7:0] b);
    if ((b & udwc_pkg::ASCII_MASK) == udwc_pkg::ASCII_CODE) begin
      bump_columns(glyph_columns({13'd0, b}));
    end else if ((b & udwc_pkg::LEAD2_MASK) == udwc_pkg::LEAD2_CODE) begin
      seq_want = udwc_pkg::SEQ_TWO;
      seq_have = 3'd1;
      cp_acc   = {16'd0, b[4:0]};
    end else if ((b & udwc_pkg::LEAD3_MASK) == udwc_pkg::LEAD3_CODE) begin
      seq_want = udwc_pkg::SEQ_THREE;
      seq_have = 3'd1;
      cp_acc   = {17'd0, b[3:0]};
    end else if ((b & udwc_pkg::LEAD4_MASK) == udwc_pkg::LEAD4_CODE) begin
      seq_want = udwc_pkg::SEQ_FOUR;
      seq_have = 3'd1;
      cp_acc   = {18'd0, b[2:0]};
    end else begin
      // Stray continuation or a byte that can never start a sequence.
      bump_columns(1);
    end
  endfunction

  // Advance the predictor by one accepted byte; return 1 with the range total
  // when the byte closes the range.
  function bit width_step(input logic [7:0] b, input logic l,
                          output logic [15:0] cols, output logic sat);
    cols = '0;
    sat  = 1'b0;
    if (seq_want != udwc_pkg::SEQ_NONE) begin
      if ((b & udwc_pkg::CONT_MASK) == udwc_pkg::CONT_CODE) begin
        cp_acc   = {cp_acc[14:0], b[5:0]};
        seq_have = seq_have + 3'd1;
        if (seq_have >= seq_want) begin
          bump_columns(glyph_columns(cp_acc));
          drop_pending();
        end
      end else begin
        // Broken sequence: bytes held so far count one each, then restart.
        bump_columns(seq_have);
        drop_pending();
        take_lead_octet(b);
      end
    end else begin
      take_lead_octet(b);
    end
    if (!l) begin
      return 1'b0;
    end
    // Truncated at the end: flush what is held.
    if (seq_want != udwc_pkg::SEQ_NONE) begin
      bump_columns(seq_have);
      drop_pending();
    end
    cols    = col_sum[15:0];
    sat     = col_sat;
    col_sum = 0;
    col_sat = 1'b0;
    return 1'b1;
  endfunction

  function automatic script_row_t mk_row(input logic [7:0] o, input logic l,
                                         input int unsigned n, input logic t,
                                         input logic [15:0] c, input logic s);
    script_row_t r;
    r.octet = o;
    r.last  = l;
    r.reps  = n;
    r.typed = t;
    r.cols  = c;
    r.sat   = s;
    return r;
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Append one text unit to the random range: mostly a well-formed code point
  // (table edges favored, sometimes overlong), else a cut-short sequence,
  // a random byte or a lone continuation byte.
  function void append_unit();
    int unsigned pick;
    int unsigned kind;
    int unsigned n_len;
    int unsigned keep;
    int unsigned k;
    logic [20:0] cp;
    logic [7:0]  enc [0:3];
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      range_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      return;
    end
    if (pick >= 88) begin
      range_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    kind = $urandom_range(0, 5);
    case (kind)
      0: begin
        cp = 21'($urandom_range(0, 'h7F));
      end
      1: begin
        cp = 21'($urandom_range('h80, 'h7FF));
      end
      2: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
      end
      3: begin
        cp = 21'($urandom_range('h10000, 'h1FFFFF));
      end
      default: begin
        cp = CP_EDGES[$urandom_range(0, 27)] - 21'd1 + 21'($urandom_range(0, 2));
      end
    endcase
    n_len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    if (n_len < 4 && $urandom_range(0, 19) == 0) begin
      n_len = n_len + 1;
    end
    case (n_len)
      1: begin
        enc[0] = {1'b0, cp[6:0]};
      end
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    keep = n_len;
    if (pick >= 80 && n_len > 1) begin
      keep = $urandom_range(1, n_len - 1);
    end
    for (k = 0; k < keep; k++) begin
      range_bytes.push_back(enc[k]);
    end
  endfunction

  // Offer one byte, hold it until the block takes it, then predict. Typed rows
  // owe the total written in the script instead of the predicted one.
  task automatic send_octet(input logic [7:0] v, input logic l, input bit gaps_on,
                            input logic typed, input logic [15:0] t_cols,
                            input logic t_sat);
    int unsigned  gap;
    range_total_t due;
    logic [15:0]  p_cols;
    logic         p_sat;
    gap = gaps_on ? pick_gap() : 0;
    // Lower valid only for a real gap, so valid never drops and rises in one step.
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= v;
    text_ch.last_byte <= l;
    do begin
      @(posedge clk);
    end while (!text_ch.ready);
    if (width_step(v, l, p_cols, p_sat)) begin
      due.cols = typed ? t_cols : p_cols;
      due.sat  = typed ? t_sat : p_sat;
      totals_due.push_back(due);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus: directed script first, then random ranges.
  initial begin
    int unsigned i;
    int unsigned j;
    int unsigned n_units;
    int unsigned rand_sent;
    bit          burst;
    script_row_t row_now;

    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= 8'h00;
    text_ch.last_byte <= 1'b0;

    // Single ASCII and stray bytes: one column each.
    script.push_back(mk_row(8'h41, 1'b1, 1, 1'b1, 16'd1, 1'b0));
    script.push_back(mk_row(8'h00, 1'b1, 1, 1'b1, 16'd1, 1'b0));
    script.push_back(mk_row(8'h7F, 1'b1, 1, 1'b1, 16'd1, 1'b0));
    // Tab is not special: still one column.
    script.push_back(mk_row(8'h09, 1'b1, 1, 1'b1, 16'd1, 1'b0));
    script.push_back(mk_row(8'hFF, 1'b1, 1, 1'b1, 16'd1, 1'b0));
    // Lone continuation byte.
    script.push_back(mk_row(8'h80, 1'b1, 1, 1'b1, 16'd1, 1'b0));
    // Combining grave accent, two bytes, zero columns.
    script.push_back(mk_row(8'hCC, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h80, 1'b1, 1, 1'b0, 16'd0, 1'b0));
    // Overlong NUL passes as a code point.
    script.push_back(mk_row(8'hC0, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h80, 1'b1, 1, 1'b0, 16'd0, 1'b0));
    // Hangul syllable, three bytes, wide.
    script.push_back(mk_row(8'hEA, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'hB0, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h80, 1'b1, 1, 1'b0, 16'd0, 1'b0));
    // Emoji, four bytes, wide.
    script.push_back(mk_row(8'hF0, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h9F, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h98, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h80, 1'b1, 1, 1'b0, 16'd0, 1'b0));
    // Broken sequence: lead counts one, the breaking ASCII byte one more.
    script.push_back(mk_row(8'hE4, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h41, 1'b1, 1, 1'b1, 16'd2, 1'b0));
    // Truncated at the end: lead and held continuation count one each.
    script.push_back(mk_row(8'hF0, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h9F, 1'b1, 1, 1'b1, 16'd2, 1'b0));
    // Broken after a held continuation; the breaking byte opens a new sequence.
    script.push_back(mk_row(8'hE4, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'hB8, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'hC3, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'hA9, 1'b1, 1, 1'b0, 16'd0, 1'b0));
    // Four-byte sequence broken with three bytes held, plus the breaking byte.
    script.push_back(mk_row(8'hF0, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h9F, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h98, 1'b0, 1, 1'b0, 16'd0, 1'b0));
    script.push_back(mk_row(8'h41, 1'b1, 1, 1'b1, 16'd4, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the script; repeated rows go out back to back.
    for (i = 0; i < script.size(); i++) begin
      row_now = script[i];
      for (j = 0; j < row_now.reps; j++) begin
        send_octet(row_now.octet, row_now.last && (j == row_now.reps - 1),
                   row_now.reps == 1, row_now.typed, row_now.cols, row_now.sat);
      end
    end

    // Random ranges of 1 to 12 text units; some go out as bursts with no gaps.
    rand_sent = 0;
    while (rand_sent < RANDOM_BYTES) begin
      range_bytes.delete();
      n_units = $urandom_range(1, 12);
      repeat (n_units) append_unit();
      burst = ($urandom_range(0, 4) == 0);
      for (i = 0; i < range_bytes.size(); i++) begin
        send_octet(range_bytes[i], i == range_bytes.size() - 1, !burst,
                   1'b0, 16'd0, 1'b0);
      end
      rand_sent = rand_sent + range_bytes.size();
    end
    text_ch.valid <= 1'b0;

    // Wait out the owed totals, then watch a little longer for stray results.
    while (totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_utf8_display_width_counter_top passed");
    end else begin
      $display("tb_utf8_display_width_counter_top failed");
    end
    $finish;
  end

  // Result side: check each accepted total against the oldest one owed, and
  // drive ready with random stalls, quiet stretches and one long hold-off.
  initial begin
    int unsigned  stall_left;
    int unsigned  quiet_left;
    bit           squeezed;
    range_total_t due;

    stall_left     = 0;
    quiet_left     = 0;
    squeezed       = 1'b0;
    width_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && width_ch.valid && width_ch.ready) begin
        n_results = n_results + 1;
        if (totals_due.size() == 0) begin
          $display("%0t: result with nothing owed: column_width %0d saturated %0b",
                   $time, width_ch.column_width, width_ch.saturated);
          err_cnt = err_cnt + 1;
        end else begin
          due = totals_due.pop_front();
          if (width_ch.column_width !== due.cols) begin
            $display("%0t: column_width expected %0d, got %0d",
                     $time, due.cols, width_ch.column_width);
            err_cnt = err_cnt + 1;
          end
          if (width_ch.saturated !== due.sat) begin
            $display("%0t: saturated expected %0b, got %0b",
                     $time, due.sat, width_ch.saturated);
            err_cnt = err_cnt + 1;
          end
        end
      end
      // Hold off once for a long stretch so the block fills and stalls its input.
      if (!squeezed && n_results == SQUEEZE_AT) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_LEN;
      end
      if (stall_left > 0) begin
        stall_left     = stall_left - 1;
        width_ch.ready <= 1'b0;
      end else begin
        width_ch.ready <= 1'b1;
        if (quiet_left > 0) begin
          quiet_left = quiet_left - 1;
        end else if ($urandom_range(0, 99) < 3) begin
          quiet_left = $urandom_range(40, 150);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((text_ch.valid && text_ch.ready) || (width_ch.valid && width_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("tb_utf8_display_width_counter_top failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/udwc_pkg.sv
hw/rtl/udwc_if.sv
hw/rtl/udwc_front.sv
hw/rtl/udwc_queue.sv
hw/rtl/udwc_back.sv
hw/rtl/utf8_display_width_counter_top.sv
hw/rtl/udwc_checker.sv
tb/tb_utf8_display_width_counter_top.sv
